### src/rtcdw_pkg.sv
// ----------------------------------------------------------------------------
// rtcdw_pkg
// Shared types, constants and helper functions for the RTC date check core.
// ----------------------------------------------------------------------------
package rtcdw_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_MONTHEND = 2'd2
    } status_t;

    // Field range limits
    localparam logic [7:0] SEC_MAX   = 8'd59;
    localparam logic [7:0] MIN_MAX   = 8'd59;
    localparam logic [7:0] HOUR_MAX  = 8'd23;
    localparam logic [7:0] DAY_MAX   = 8'd31;
    localparam logic [7:0] MONTH_MAX = 8'd12;
    localparam logic [7:0] YEAR_MAX  = 8'd99;

    // Packed stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    // Non-leap month length, month 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:                       len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // Days before the month, reduced mod 7
    function automatic logic [2:0] days_before_mod7(input logic [3:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;  // 0
            4'd2:    r = 3'd3;  // 31
            4'd3:    r = 3'd3;  // 59
            4'd4:    r = 3'd6;  // 90
            4'd5:    r = 3'd1;  // 120
            4'd6:    r = 3'd4;  // 151
            4'd7:    r = 3'd6;  // 181
            4'd8:    r = 3'd2;  // 212
            4'd9:    r = 3'd5;  // 243
            4'd10:   r = 3'd0;  // 273
            4'd11:   r = 3'd3;  // 304
            4'd12:   r = 3'd5;  // 334
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Two BCD digits of v (v in 0..99); tens digit via multiply by 205/2048
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        return 8'(v) + 8'(tens) * 8'd6;
    endfunction

    // s mod 7 for s in 0..255: quotient estimate 73/512 is floor or floor-1
    function automatic logic [2:0] mod7(input logic [7:0] s);
        logic [15:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        prod = 16'(s) * 16'd73;
        q    = 8'(prod >> 9);
        r    = s - 8'(q * 8'd7);
        if (r >= 8'd7)
        begin
            r = r - 8'd7;
        end
        return r[2:0];
    endfunction

endpackage

### src/rtc_date_check_weekday_bcd_core.sv
// ----------------------------------------------------------------------------
// rtc_date_check_weekday_bcd_core
// Checks a binary date/time, computes the weekday and packs RTC BCD bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one item per date/time, six binary bytes in
//   s_axis_tdata. Output stream (m_axis_*): one item per input item, the
//   status in m_axis_tuser and the seven BCD register fields in m_axis_tdata.
//   Status 0 is ok, 1 a field out of range, 2 a day past the month's end
//   (29 February included); on any error all BCD fields are zero.
//   The item is captured in an input register; the checks, weekday and BCD
//   encoding run in one pass and land in the result register. Throughput
//   is one item per cycle; both registers advance together whenever the
//   result register is empty or being taken.
//   When the receiver stalls, the result holds and the input register still
//   takes one more item; s_axis_tready drops only when both are full.
//   Reset clears both valid flags; no other state is kept.
// ----------------------------------------------------------------------------
module rtc_date_check_weekday_bcd_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] year_in, [15:8] month_in, [23:16] day_in, [31:24] hour_in,
    // [39:32] minute_in, [47:40] second_in
    input  logic [47:0] s_axis_tdata,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] second_bcd, [13:7] minute_bcd, [19:14] hour_bcd,
    // [22:20] weekday_bcd, [28:23] day_bcd, [33:29] month_bcd,
    // [41:34] year_bcd, [47:42] zero
    output logic [47:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    // Pipeline control
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic        advance;

    // Input register
    logic [47:0] in_data_reg;

    // Result register
    logic [47:0] out_data_reg;
    logic [47:0] out_data_next;
    rtcdw_pkg::status_t out_status_reg;
    rtcdw_pkg::status_t out_status_next;

    // Unpacked input fields
    logic [7:0]  year_v;
    logic [7:0]  month_v;
    logic [7:0]  day_v;
    logic [7:0]  hour_v;
    logic [7:0]  minute_v;
    logic [7:0]  second_v;

    // Check and weekday intermediates
    logic        range_err;
    logic        monthend_err;
    logic        leap_add;
    logic [4:0]  quad_cnt;
    logic [7:0]  wd_sum;
    logic [2:0]  weekday;

    // BCD encodings of the fields
    logic [7:0]  second_bcd_v;
    logic [7:0]  minute_bcd_v;
    logic [7:0]  hour_bcd_v;
    logic [7:0]  day_bcd_v;
    logic [7:0]  month_bcd_v;
    logic [7:0]  year_bcd_v;

    // Handshake: both stages move when the result slot frees up
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    assign year_v   = in_data_reg[7:0];
    assign month_v  = in_data_reg[15:8];
    assign day_v    = in_data_reg[23:16];
    assign hour_v   = in_data_reg[31:24];
    assign minute_v = in_data_reg[39:32];
    assign second_v = in_data_reg[47:40];

    // Range and month-length checks
    always_comb
    begin
        range_err = (second_v > rtcdw_pkg::SEC_MAX) || (minute_v > rtcdw_pkg::MIN_MAX) ||
                    (hour_v > rtcdw_pkg::HOUR_MAX) || (day_v == 8'd0) ||
                    (day_v > rtcdw_pkg::DAY_MAX) || (month_v == 8'd0) ||
                    (month_v > rtcdw_pkg::MONTH_MAX) || (year_v > rtcdw_pkg::YEAR_MAX);
        monthend_err = (day_v > 8'(rtcdw_pkg::month_len(month_v[3:0])));
    end

    // Weekday: 365 = 1 mod 7, so the sum reduces to small terms
    always_comb
    begin
        leap_add = (month_v[3:0] > 4'd2) && (year_v[1:0] == 2'b00);
        quad_cnt = 5'((year_v[6:0] + 7'd3) >> 2);
        wd_sum   = 8'(day_v[4:0]) + 8'(rtcdw_pkg::days_before_mod7(month_v[3:0])) +
                   8'(leap_add) + 8'(year_v[6:0]) + 8'(quad_cnt) + 8'd5;
        weekday  = rtcdw_pkg::mod7(wd_sum);
    end

    // Two-digit BCD of each field
    assign second_bcd_v = rtcdw_pkg::to_bcd(second_v[6:0]);
    assign minute_bcd_v = rtcdw_pkg::to_bcd(minute_v[6:0]);
    assign hour_bcd_v   = rtcdw_pkg::to_bcd(hour_v[6:0]);
    assign day_bcd_v    = rtcdw_pkg::to_bcd(day_v[6:0]);
    assign month_bcd_v  = rtcdw_pkg::to_bcd(month_v[6:0]);
    assign year_bcd_v   = rtcdw_pkg::to_bcd(year_v[6:0]);

    // Result assembly
    always_comb
    begin
        out_data_next = '0;
        if (range_err)
        begin
            out_status_next = rtcdw_pkg::ST_RANGE;
        end
        else if (monthend_err)
        begin
            out_status_next = rtcdw_pkg::ST_MONTHEND;
        end
        else
        begin
            out_status_next       = rtcdw_pkg::ST_OK;
            out_data_next[6:0]    = second_bcd_v[6:0];
            out_data_next[13:7]   = minute_bcd_v[6:0];
            out_data_next[19:14]  = hour_bcd_v[5:0];
            out_data_next[22:20]  = weekday;
            out_data_next[28:23]  = day_bcd_v[5:0];
            out_data_next[33:29]  = month_bcd_v[4:0];
            out_data_next[41:34]  = year_bcd_v;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    // Checks
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("invalid status code on output");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != rtcdw_pkg::ST_OK)) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero data");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:20] != 3'd7))
        else $error("weekday out of range");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with a free slot");

endmodule
